// ===== src/rcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_pkg
// Shared constants, codes and helpers for the raster-to-cube reorder core.
// ----------------------------------------------------------------------------
package rcr_pkg;

   // block geometry
   localparam int BLOCK_WIDTH      = 8;
   localparam int BLOCK_HEIGHT     = 8;
   localparam int BLOCK_DEPTH      = 8;
   localparam int MAX_FRAME_WIDTH  = 128;
   localparam int MAX_FRAME_HEIGHT = 128;

   // frame store
   localparam int STORE_SIZE = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT * BLOCK_DEPTH;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int GRP_W      = $clog2(STORE_SIZE + 1);
   localparam int PIX_W      = 8;

   // registers and counters
   localparam int REG_W   = 8;
   localparam int WH_W    = 2 * REG_W;
   localparam int COL_W   = (BLOCK_WIDTH  > 1) ? $clog2(BLOCK_WIDTH)  : 1;
   localparam int ROW_W   = (BLOCK_HEIGHT > 1) ? $clog2(BLOCK_HEIGHT) : 1;
   localparam int FRM_W   = (BLOCK_DEPTH  > 1) ? $clog2(BLOCK_DEPTH)  : 1;
   localparam int CSR_IDX_W = 2;

   // status codes
   localparam logic [1:0] ST_WRITE_OK = 2'd0;
   localparam logic [1:0] ST_READ_OK  = 2'd1;
   localparam logic [1:0] ST_REJECT   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // clamp to the frame limit, then round down to a multiple of the block size
   function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v,
                                                input int maxv, input int blk);
      int vi;
      logic [REG_W-1:0] res;
      vi  = int'(v);
      res = '0;
      if (vi > maxv) vi = maxv;
      for (int k = 1; k * blk <= (1 << REG_W) - 1; k++) begin
         if (k * blk <= vi) res = REG_W'(k * blk);
      end
      return res;
   endfunction

   localparam logic [REG_W-1:0] W_RST  = eff_dim(8'd128, MAX_FRAME_WIDTH, BLOCK_WIDTH);
   localparam logic [REG_W-1:0] H_RST  = eff_dim(8'd128, MAX_FRAME_HEIGHT, BLOCK_HEIGHT);
   localparam logic [WH_W-1:0]  WH_RST = WH_W'(int'(W_RST) * int'(H_RST));
   localparam logic [ADDR_W-1:0] BHW_RST = ADDR_W'(BLOCK_HEIGHT * int'(W_RST));

endpackage

// ===== src/raster_to_cube_reorder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_to_cube_reorder_core
// Collects a group of frames in raster order into a frame store and hands
// the pixels back in cube order (block row, block column, frame, row, col).
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   req_func, req_pixel_in             start & !busy
//  response  rsp_pixel_out, rsp_status, rsp_last  rsp_valid, one cycle
//  config    csr_index, csr_wdata               csr_we
//
//  One transaction per clock while busy is low: the response shows in the
//  cycle after the request is taken, as the frame store's read data is registered.
//  busy is high only during reset and in the cycle after it; no clearing pass is needed.
//  The response side cannot stall, so nothing is buffered beyond one stage.
//  The read address comes from incrementally updated base registers.
// ----------------------------------------------------------------------------
module raster_to_cube_reorder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [rcr_pkg::PIX_W-1:0]     req_pixel_in,
   output logic                          rsp_valid,
   output logic [rcr_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [rcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcr_pkg::REG_W-1:0]     csr_wdata
);

   localparam int AW = rcr_pkg::ADDR_W;
   localparam int GW = rcr_pkg::GRP_W;
   localparam int RW = rcr_pkg::REG_W;

   // geometry
   logic [RW-1:0]               w_ff, w_in, h_ff, h_in;
   logic [rcr_pkg::WH_W-1:0]    wh_ff, wh_in;
   logic [AW-1:0]               bhw_ff, bhw_in;
   logic [GW-1:0]               grp;
   logic [RW-1:0]               w_new, h_new;

   // group state
   logic                        full_ff, full_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [rcr_pkg::COL_W-1:0]   c_ff, c_in;
   logic [rcr_pkg::ROW_W-1:0]   r_ff, r_in;
   logic [rcr_pkg::FRM_W-1:0]   f_ff, f_in;
   logic [RW-1:0]               col_org_ff, col_org_in;
   logic [AW-1:0]               row_org_ff, row_org_in;
   logic [AW-1:0]               blk_base_ff, blk_base_in;
   logic [AW-1:0]               frm_base_ff, frm_base_in;
   logic [AW-1:0]               line_base_ff, line_base_in;

   // response
   logic                        busy_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rd_ok_ff;

   logic                        accept, ok_wr, ok_rd, grp_end, col_last;
   logic                        ram_en;
   logic [AW-1:0]               ram_addr;
   logic [rcr_pkg::PIX_W-1:0]   ram_q;

   assign accept   = start & ~busy_ff;
   assign grp      = GW'(int'(wh_ff) * rcr_pkg::BLOCK_DEPTH);
   assign ok_wr    = accept & (wh_ff != '0) & ~req_func & ~full_ff;
   assign ok_rd    = accept & (wh_ff != '0) & req_func & full_ff;
   assign grp_end  = (GW'(idx_ff) + GW'(1)) == grp;
   assign col_last = ({1'b0, col_org_ff} + (RW + 1)'(rcr_pkg::BLOCK_WIDTH))
                     >= {1'b0, w_ff};
   assign w_new    = rcr_pkg::eff_dim(csr_wdata, rcr_pkg::MAX_FRAME_WIDTH,
                                      rcr_pkg::BLOCK_WIDTH);
   assign h_new    = rcr_pkg::eff_dim(csr_wdata, rcr_pkg::MAX_FRAME_HEIGHT,
                                      rcr_pkg::BLOCK_HEIGHT);

   assign ram_en   = ok_wr | ok_rd;
   assign ram_addr = ok_wr ? idx_ff : (line_base_ff + AW'(c_ff));

   rcr_ram #(
      .WIDTH (rcr_pkg::PIX_W),
      .DEPTH (rcr_pkg::STORE_SIZE)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ok_wr),
      .addr  (ram_addr),
      .wdata (req_pixel_in),
      .rdata (ram_q)
   );

   always_comb begin
      w_in          = w_ff;
      h_in          = h_ff;
      wh_in         = wh_ff;
      bhw_in        = bhw_ff;
      full_in       = full_ff;
      idx_in        = idx_ff;
      c_in          = c_ff;
      r_in          = r_ff;
      f_in          = f_ff;
      col_org_in    = col_org_ff;
      row_org_in    = row_org_ff;
      blk_base_in   = blk_base_ff;
      frm_base_in   = frm_base_ff;
      line_base_in  = line_base_ff;
      rsp_status_in = rcr_pkg::ST_REJECT;
      rsp_last_in   = 1'b0;

      if (ok_wr) begin
         rsp_status_in = rcr_pkg::ST_WRITE_OK;
         if (grp_end) begin
            idx_in      = '0;
            full_in     = 1'b1;
            rsp_last_in = 1'b1;
         end else begin
            idx_in = idx_ff + AW'(1);
         end
      end else if (ok_rd) begin
         rsp_status_in = rcr_pkg::ST_READ_OK;
         idx_in        = idx_ff + AW'(1);
         if (c_ff == rcr_pkg::COL_W'(rcr_pkg::BLOCK_WIDTH - 1)) begin
            c_in = '0;
            if (r_ff == rcr_pkg::ROW_W'(rcr_pkg::BLOCK_HEIGHT - 1)) begin
               r_in = '0;
               if (f_ff == rcr_pkg::FRM_W'(rcr_pkg::BLOCK_DEPTH - 1)) begin
                  f_in = '0;
                  // next block: step column, wrap into the next block row
                  if (col_last) begin
                     col_org_in  = '0;
                     row_org_in  = row_org_ff + bhw_ff;
                     blk_base_in = row_org_ff + bhw_ff;
                  end else begin
                     col_org_in  = col_org_ff + RW'(rcr_pkg::BLOCK_WIDTH);
                     blk_base_in = blk_base_ff + AW'(rcr_pkg::BLOCK_WIDTH);
                  end
                  frm_base_in  = blk_base_in;
                  line_base_in = blk_base_in;
               end else begin
                  f_in         = f_ff + rcr_pkg::FRM_W'(1);
                  frm_base_in  = frm_base_ff + AW'(wh_ff);
                  line_base_in = frm_base_ff + AW'(wh_ff);
               end
            end else begin
               r_in         = r_ff + rcr_pkg::ROW_W'(1);
               line_base_in = line_base_ff + AW'(w_ff);
            end
         end else begin
            c_in = c_ff + rcr_pkg::COL_W'(1);
         end
         if (grp_end) begin
            rsp_last_in = 1'b1;
            full_in     = 1'b0;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            rcr_pkg::CSR_FRAME_WIDTH: begin
               w_in   = w_new;
               wh_in  = {{RW{1'b0}}, w_new} * {{RW{1'b0}}, h_ff};
               bhw_in = AW'(rcr_pkg::BLOCK_HEIGHT * int'(w_new));
            end
            rcr_pkg::CSR_FRAME_HEIGHT: begin
               h_in  = h_new;
               wh_in = {{RW{1'b0}}, w_ff} * {{RW{1'b0}}, h_new};
            end
            default: begin
            end
         endcase
      end

      // group restart after the final read or on a write to the width or height register
      if ((ok_rd && grp_end) ||
          (csr_we && (csr_index == rcr_pkg::CSR_FRAME_WIDTH ||
                      csr_index == rcr_pkg::CSR_FRAME_HEIGHT))) begin
         full_in      = 1'b0;
         idx_in       = '0;
         c_in         = '0;
         r_in         = '0;
         f_in         = '0;
         col_org_in   = '0;
         row_org_in   = '0;
         blk_base_in  = '0;
         frm_base_in  = '0;
         line_base_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         w_ff          <= rcr_pkg::W_RST;
         h_ff          <= rcr_pkg::H_RST;
         wh_ff         <= rcr_pkg::WH_RST;
         bhw_ff        <= rcr_pkg::BHW_RST;
         full_ff       <= 1'b0;
         idx_ff        <= '0;
         c_ff          <= '0;
         r_ff          <= '0;
         f_ff          <= '0;
         col_org_ff    <= '0;
         row_org_ff    <= '0;
         blk_base_ff   <= '0;
         frm_base_ff   <= '0;
         line_base_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= rcr_pkg::ST_REJECT;
         rsp_last_ff   <= 1'b0;
         rd_ok_ff      <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         w_ff          <= w_in;
         h_ff          <= h_in;
         wh_ff         <= wh_in;
         bhw_ff        <= bhw_in;
         full_ff       <= full_in;
         idx_ff        <= idx_in;
         c_ff          <= c_in;
         r_ff          <= r_in;
         f_ff          <= f_in;
         col_org_ff    <= col_org_in;
         row_org_ff    <= row_org_in;
         blk_base_ff   <= blk_base_in;
         frm_base_ff   <= frm_base_in;
         line_base_ff  <= line_base_in;
         rsp_valid_ff  <= accept;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rd_ok_ff      <= ok_rd;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_pixel_out = rd_ok_ff ? ram_q : '0;

endmodule

// ===== src/rcr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcr_ram
// Generic single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module rcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== tb/sv/raster_to_cube_reorder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_to_cube_reorder_core_tb
// Self-checking bench for the raster-to-cube reorder core. A clocked driver
// feeds pixel writes and cube-order reads from a pending queue; a scoreboard
// model of the frame store predicts status, pixel and last for every
// accepted transaction, and a clocked monitor compares each response
// against the oldest prediction. Frame geometry is changed between phases,
// covering empty, clamped and rounded sizes, with a group filled, read part
// way and then abandoned.
// ----------------------------------------------------------------------------
module raster_to_cube_reorder_core_tb;

   typedef enum logic {
      PIX_WRITE = 1'b0,
      PIX_READ  = 1'b1
   } pix_op_type;

   typedef struct {
      pix_op_type                op;
      logic [rcr_pkg::PIX_W-1:0] pix;
   } pix_req_type;

   typedef struct {
      logic [rcr_pkg::PIX_W-1:0] pixel;
      logic [1:0]                status;
      logic                      last;
   } cube_rsp_type;

   // indexes past the register list, expected to be ignored
   localparam logic [rcr_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rcr_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int NOISE_PCT   = 6;
   localparam int STALL_LIMIT = 1000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_func = 1'b0;
   logic [rcr_pkg::PIX_W-1:0]     req_pixel_in = '0;
   logic                          rsp_valid;
   logic [rcr_pkg::PIX_W-1:0]     rsp_pixel_out;
   logic [1:0]                    rsp_status;
   logic                          rsp_last;
   logic                          csr_we = 1'b0;
   logic [rcr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rcr_pkg::REG_W-1:0]     csr_wdata = '0;

   pix_req_type  pending_pix_q[$];
   cube_rsp_type cube_rsp_q[$];
   int           idle_pct = 0;
   int           mismatch_cnt = 0;
   int           stall_cycles = 0;

   // scoreboard copy of the frame store and its counters
   logic [rcr_pkg::PIX_W-1:0] fstore [rcr_pkg::STORE_SIZE];
   logic [rcr_pkg::REG_W-1:0] cfg_width;
   logic [rcr_pkg::REG_W-1:0] cfg_height;
   int                        wr_pos;
   int                        rd_count;
   bit                        grp_ready;
   int                        blk_row, blk_col, frm_sel, row_in, col_in;

   raster_to_cube_reorder_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_pixel_in (req_pixel_in),
      .rsp_valid    (rsp_valid),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int eff_w();
      int v;
      v = (int'(cfg_width) > rcr_pkg::MAX_FRAME_WIDTH) ?
          rcr_pkg::MAX_FRAME_WIDTH : int'(cfg_width);
      return v - v % rcr_pkg::BLOCK_WIDTH;
   endfunction

   function automatic int eff_h();
      int v;
      v = (int'(cfg_height) > rcr_pkg::MAX_FRAME_HEIGHT) ?
          rcr_pkg::MAX_FRAME_HEIGHT : int'(cfg_height);
      return v - v % rcr_pkg::BLOCK_HEIGHT;
   endfunction

   function automatic int group_size();
      return eff_w() * eff_h() * rcr_pkg::BLOCK_DEPTH;
   endfunction

   function automatic void restart_group();
      wr_pos    = 0;
      rd_count  = 0;
      grp_ready = 1'b0;
      blk_row   = 0;
      blk_col   = 0;
      frm_sel   = 0;
      row_in    = 0;
      col_in    = 0;
   endfunction

   // expected response of one transaction; advances the scoreboard state
   function automatic cube_rsp_type predict_cube(input pix_op_type op,
                                                 input logic [rcr_pkg::PIX_W-1:0] pix);
      cube_rsp_type r;
      int w, h, gsize, x, y, addr;
      w        = eff_w();
      h        = eff_h();
      gsize    = w * h * rcr_pkg::BLOCK_DEPTH;
      r.pixel  = '0;
      r.status = rcr_pkg::ST_REJECT;
      r.last   = 1'b0;
      if (gsize != 0 && op == PIX_WRITE && !grp_ready && wr_pos < gsize) begin
         fstore[wr_pos] = pix;
         wr_pos++;
         r.status = rcr_pkg::ST_WRITE_OK;
         if (wr_pos >= gsize) begin
            wr_pos    = 0;
            grp_ready = 1'b1;
            r.last    = 1'b1;
         end
      end else if (gsize != 0 && op == PIX_READ && grp_ready) begin
         y    = blk_row * rcr_pkg::BLOCK_HEIGHT + row_in;
         x    = blk_col * rcr_pkg::BLOCK_WIDTH + col_in;
         addr = frm_sel * w * h + y * w + x;
         if (addr < rcr_pkg::STORE_SIZE) r.pixel = fstore[addr];
         r.status = rcr_pkg::ST_READ_OK;
         rd_count++;
         // column, row, frame, block column, block row
         if (++col_in >= rcr_pkg::BLOCK_WIDTH) begin
            col_in = 0;
            if (++row_in >= rcr_pkg::BLOCK_HEIGHT) begin
               row_in = 0;
               if (++frm_sel >= rcr_pkg::BLOCK_DEPTH) begin
                  frm_sel = 0;
                  if (++blk_col >= w / rcr_pkg::BLOCK_WIDTH) begin
                     blk_col = 0;
                     blk_row++;
                  end
               end
            end
         end
         if (rd_count >= gsize || blk_row >= h / rcr_pkg::BLOCK_HEIGHT) begin
            restart_group();
            r.last = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic push_item(input pix_op_type op, input logic [rcr_pkg::PIX_W-1:0] pix);
      pending_pix_q.push_back('{op: op, pix: pix});
   endtask

   // n transactions of one kind, with a sprinkle of the other kind mixed in
   task automatic queue_stage(input pix_op_type op, input pix_op_type noise, input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < NOISE_PCT) push_item(noise, rcr_pkg::PIX_W'($urandom));
         push_item(op, rcr_pkg::PIX_W'($urandom));
      end
   endtask

   task automatic wait_idle();
      while (pending_pix_q.size() != 0 || cube_rsp_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rcr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rcr_pkg::REG_W-1:0] val);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rcr_pkg::CSR_FRAME_WIDTH) begin
         cfg_width = val;
         restart_group();
      end else if (idx == rcr_pkg::CSR_FRAME_HEIGHT) begin
         cfg_height = val;
         restart_group();
      end
   endtask

   task automatic report_field(input string fld, input logic [rcr_pkg::PIX_W-1:0] want,
                               input logic [rcr_pkg::PIX_W-1:0] got);
      $display("%0t ERROR %s expected %0h actual %0h", $time, fld, want, got);
      mismatch_cnt++;
   endtask

   // request driver: the scoreboard is updated when a transaction is taken
   always @(posedge clock) begin : req_drive
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            cube_rsp_q.push_back(predict_cube(pix_op_type'(req_func), req_pixel_in));
            void'(pending_pix_q.pop_front());
         end
         if (pending_pix_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            start        <= 1'b1;
            req_func     <= pending_pix_q[0].op;
            req_pixel_in <= pending_pix_q[0].pix;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      cube_rsp_type want;
      if (!reset && rsp_valid) begin
         if (cube_rsp_q.size() == 0) begin
            $display("%0t ERROR unexpected response: pixel_out %0h status %0d last %0d",
                     $time, rsp_pixel_out, rsp_status, rsp_last);
            mismatch_cnt++;
         end else begin
            want = cube_rsp_q.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_field("pixel_out", want.pixel, rsp_pixel_out);
            if (rsp_status !== want.status)
               report_field("status", rcr_pkg::PIX_W'(want.status),
                            rcr_pkg::PIX_W'(rsp_status));
            if (rsp_last !== want.last)
               report_field("last", rcr_pkg::PIX_W'(want.last), rcr_pkg::PIX_W'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ERROR no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      cfg_width  = 8'd128;
      cfg_height = 8'd128;
      restart_group();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // full-size geometry: early read rejected, extreme pixel values stored
      push_item(PIX_READ, 8'h00);
      push_item(PIX_WRITE, 8'h00);
      push_item(PIX_WRITE, 8'hFF);
      push_item(PIX_WRITE, 8'h55);
      push_item(PIX_WRITE, 8'hAA);
      push_item(PIX_READ, 8'hFF);

      // oversize width clamps; height below one block leaves an empty frame
      write_reg(rcr_pkg::CSR_FRAME_WIDTH, 8'hFF);
      write_reg(rcr_pkg::CSR_FRAME_HEIGHT, 8'd7);
      push_item(PIX_WRITE, 8'h12);
      push_item(PIX_READ, 8'h00);
      write_reg(rcr_pkg::CSR_FRAME_HEIGHT, 8'h00);
      write_reg(rcr_pkg::CSR_FRAME_WIDTH, 8'h00);
      push_item(PIX_WRITE, 8'hFF);
      push_item(PIX_READ, 8'h00);

      // width 15 rounds down to one block; spare indexes must not restart
      write_reg(rcr_pkg::CSR_FRAME_WIDTH, 8'd15);
      write_reg(rcr_pkg::CSR_FRAME_HEIGHT, 8'd8);
      push_item(PIX_WRITE, 8'h01);
      push_item(PIX_WRITE, 8'h80);
      push_item(PIX_WRITE, 8'h7F);
      write_reg(CSR_SPARE_2, 8'hFF);
      write_reg(CSR_SPARE_3, 8'h00);

      // no idling
      idle_pct = 0;
      queue_stage(PIX_WRITE, PIX_READ, 200);
      wait_idle();

      // sender mostly idle
      idle_pct = 64;
      queue_stage(PIX_WRITE, PIX_READ, 150);
      wait_idle();

      // receiver cannot stall, so this phase runs back to back; group fills
      idle_pct = 0;
      queue_stage(PIX_WRITE, PIX_READ, group_size() - wr_pos);
      queue_stage(PIX_READ, PIX_WRITE, 64);
      wait_idle();

      // sender idle now and then; reads cross into later frames
      idle_pct = 31;
      queue_stage(PIX_READ, PIX_WRITE, 96);
      wait_idle();

      // new height abandons the group part way through the reads
      write_reg(rcr_pkg::CSR_FRAME_HEIGHT, 8'd16);
      push_item(PIX_WRITE, 8'h3C);
      push_item(PIX_WRITE, 8'hC3);
      push_item(PIX_WRITE, 8'h00);
      push_item(PIX_WRITE, 8'hFF);
      push_item(PIX_READ, 8'h00);

      wait_idle();
      if (mismatch_cnt == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rcr_pkg.sv
src/rcr_ram.sv
src/raster_to_cube_reorder_core.sv
tb/sv/raster_to_cube_reorder_core_tb.sv
